// ===== src/csxt_pkg.sv =====
package csxt_pkg;

    // Fixed field widths of the request and result items
    localparam int OPCODE_W  = 2;
    localparam int FUNC_ID_W = 7;
    localparam int TS_W      = 32;
    localparam int TOTAL_W   = 32;

    // Width used to compare a raw id against the function count
    localparam int ID_CMP_W  = 11;

    // Default sizing
    localparam int DEF_NUM_FUNCS   = 128;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_TIME_BITS   = 32;

    // Request opcodes; the fourth code is ignored
    localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_END   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // What the result stage does with a request
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CREDIT,
        KIND_READ
    } t_kind;

endpackage

// ===== src/call_stack_exclusive_time_unit.sv =====
// Exclusive-time tracker for a trace of call and return events. A request
// (start, end or read of one function's total) can be taken in every cycle
// unless o_stall is high; it passes through the result stage and then the
// output register. The top stack frame and the frame below it live in
// registers, so one stack memory access per request suffices, and the
// per-function totals memory is read when a request is taken and, for a
// credit, written back when it leaves the result stage, with forwarding of
// the last write. After reset a clearing pass zeroes the totals memory, one
// entry per cycle, and no request is taken until it is done.
module call_stack_exclusive_time_unit #(
    parameter int NUM_FUNCS   = csxt_pkg::DEF_NUM_FUNCS,
    parameter int STACK_DEPTH = csxt_pkg::DEF_STACK_DEPTH,
    parameter int TIME_BITS   = csxt_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [csxt_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [csxt_pkg::FUNC_ID_W-1:0] i_func_id,
    input  logic [csxt_pkg::TS_W-1:0]      i_timestamp,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_credited,
    output logic [csxt_pkg::FUNC_ID_W-1:0] o_credited_id,
    output logic [csxt_pkg::TOTAL_W-1:0]   o_total_time,
    output logic                           o_status
);

    import csxt_pkg::*;

    localparam int IDW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int RW  = TIME_BITS + 1;
    localparam int SW  = TIME_BITS + 2;
    localparam logic [TIME_BITS-1:0] TOT_MAX = '1;

    // stack state
    logic [CW-1:0]        r_count;
    logic [IDW-1:0]       r_top_id;
    logic [RW-1:0]        r_top_resume;
    logic [IDW-1:0]       r_below_id;
    logic [IDW-1:0]       stk_mem [STACK_DEPTH];

    // totals memory and clearing pass
    logic [TIME_BITS-1:0] tot_mem [NUM_FUNCS];
    logic                 r_clr_busy;
    logic [IDW-1:0]       r_clr_addr;

    // result stage
    logic                 r_s1_vld;
    t_kind                r_s1_kind;
    logic [IDW-1:0]       r_s1_addr;
    logic [RW-1:0]        r_s1_delta;
    logic                 r_s1_status;
    logic [TIME_BITS-1:0] r_s1_rdata;

    // last write-back, for forwarding
    logic                 r_fwd_vld;
    logic [IDW-1:0]       r_fwd_addr;
    logic [TIME_BITS-1:0] r_fwd_val;

    // output register
    logic                 r_out_vld;
    logic                 r_out_cred;
    logic [FUNC_ID_W-1:0] r_out_id;
    logic [TOTAL_W-1:0]   r_out_total;
    logic                 r_out_status;

    logic                 accept;
    logic                 s1_adv;
    logic [ID_CMP_W-1:0]  id_wide;
    logic [IDW-1:0]       req_id;
    logic [63:0]          ts_wide;
    logic [RW-1:0]        ev_time;
    logic                 is_event;
    logic                 stk_empty;
    logic                 stk_full;
    logic                 do_cred;
    logic                 do_pop;
    logic                 do_push;
    logic                 do_over;
    logic [RW-1:0]        delta;
    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cnt_m3;
    t_kind                req_kind;
    logic [IDW-1:0]       rd_addr;
    logic [TIME_BITS-1:0] cur_total;
    logic [SW-1:0]        sum;
    logic [TIME_BITS-1:0] sat_total;
    logic [63:0]          out_wide;

    // Handshake: stall while clearing or while the result stage is blocked
    assign s1_adv  = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_clr_busy || (r_s1_vld && !s1_adv);
    assign accept  = i_valid && !o_stall;

    // Clamp the id and pick the event time
    always_comb begin
        id_wide = ID_CMP_W'(i_func_id);
        if (id_wide >= ID_CMP_W'(NUM_FUNCS)) begin
            req_id = IDW'(NUM_FUNCS - 1);
        end else begin
            req_id = IDW'(id_wide);
        end
        ts_wide = 64'(i_timestamp);
        if (i_opcode == OP_END) begin
            ev_time = RW'(ts_wide[TIME_BITS-1:0]) + RW'(1);
        end else begin
            ev_time = RW'(ts_wide[TIME_BITS-1:0]);
        end
    end

    // Decode the stack operation
    always_comb begin
        is_event  = (i_opcode == OP_START) || (i_opcode == OP_END);
        stk_empty = (r_count == '0);
        stk_full  = (r_count == CW'(STACK_DEPTH));
        do_cred   = accept && is_event && !stk_empty;
        do_pop    = do_cred && (i_opcode == OP_END) && (req_id == r_top_id);
        do_over   = do_cred && !do_pop && stk_full;
        do_push   = do_cred && !do_pop && !stk_full;
        delta     = (ev_time >= r_top_resume) ? (ev_time - r_top_resume) : '0;
        cnt_m1    = r_count - CW'(1);
        cnt_m3    = r_count - CW'(3);
    end

    // Select what the result stage does
    always_comb begin
        unique case (i_opcode)
            OP_START, OP_END: req_kind = stk_empty ? KIND_NONE : KIND_CREDIT;
            OP_READ:          req_kind = KIND_READ;
            default:          req_kind = KIND_NONE;
        endcase
        rd_addr = (req_kind == KIND_READ) ? req_id : r_top_id;
    end

    // Track the frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept && is_event && stk_empty) begin
            r_count <= CW'(1);
        end else if (do_pop) begin
            r_count <= cnt_m1;
        end else if (do_push) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Update the top frames and the stack memory
    always_ff @(posedge i_clk) begin
        if (accept && is_event && stk_empty) begin
            r_top_id     <= req_id;
            r_top_resume <= ev_time;
        end else if (do_pop) begin
            r_top_id     <= r_below_id;
            r_top_resume <= ev_time;
            r_below_id   <= stk_mem[cnt_m3[SAW-1:0]];
        end else if (do_over) begin
            r_top_resume <= ev_time;
        end else if (do_push) begin
            stk_mem[cnt_m1[SAW-1:0]] <= r_top_id;
            r_below_id   <= r_top_id;
            r_top_id     <= req_id;
            r_top_resume <= ev_time;
        end
    end

    // Sweep the totals memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == IDW'(NUM_FUNCS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + IDW'(1);
            end
        end
    end

    // Write and read the totals memory
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            tot_mem[r_clr_addr] <= '0;
        end else if (s1_adv && (r_s1_kind == KIND_CREDIT)) begin
            tot_mem[r_s1_addr] <= sat_total;
        end
        if (accept) begin
            r_s1_rdata <= tot_mem[rd_addr];
        end
    end

    // Load the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind   <= req_kind;
            r_s1_addr   <= rd_addr;
            r_s1_delta  <= delta;
            r_s1_status <= do_over;
        end
    end

    // Forward the last write-back and saturate the new total
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur_total = r_fwd_val;
        end else begin
            cur_total = r_s1_rdata;
        end
        sum = SW'(cur_total) + SW'(r_s1_delta);
        if (sum >= SW'(TOT_MAX)) begin
            sat_total = TOT_MAX;
        end else begin
            sat_total = sum[TIME_BITS-1:0];
        end
        unique case (r_s1_kind)
            KIND_CREDIT: out_wide = 64'(sat_total);
            KIND_READ:   out_wide = 64'(cur_total);
            default:     out_wide = '0;
        endcase
    end

    // Remember the last write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (s1_adv && (r_s1_kind == KIND_CREDIT)) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && (r_s1_kind == KIND_CREDIT)) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_val  <= sat_total;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_cred   <= (r_s1_kind == KIND_CREDIT);
            r_out_id     <= (r_s1_kind == KIND_NONE) ? '0 : FUNC_ID_W'(r_s1_addr);
            r_out_total  <= out_wide[TOTAL_W-1:0];
            r_out_status <= r_s1_status;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_credited    = r_out_cred;
    assign o_credited_id = r_out_id;
    assign o_total_time  = r_out_total;
    assign o_status      = r_out_status;

endmodule

// ===== src/csxt_checker.sv =====
module csxt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [csxt_pkg::OPCODE_W-1:0]  i_opcode,
    input logic [csxt_pkg::FUNC_ID_W-1:0] i_func_id,
    input logic [csxt_pkg::TS_W-1:0]      i_timestamp,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_credited,
    input logic [csxt_pkg::FUNC_ID_W-1:0] o_credited_id,
    input logic [csxt_pkg::TOTAL_W-1:0]   o_total_time,
    input logic                           o_status
);

    import csxt_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A dropped push always comes with a credit of the top frame
    a_over_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_credited)
        else $error("overflow flagged without a credit");

    // Reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The clearing pass blocks requests right after reset
    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request taken during clearing pass");

endmodule

bind call_stack_exclusive_time_unit csxt_checker u_csxt_checker (.*);
